// ----- src/rdc_pkg.sv -----
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types and constants for the range distinct count window core.
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int VALUE_LEVELS = 1024;

  // port widths fixed by the item format
  localparam int POS_W = 11;
  localparam int COL_W = 10;
  localparam int CNT_W = 11;

  localparam int ADDR_W = $clog2(MAX_ELEMENTS);
  localparam int VAL_AW = $clog2(VALUE_LEVELS);
  localparam int FREQ_W = $clog2(MAX_ELEMENTS + 1);

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW = $clog2(CMDQ_DEPTH);
  localparam int RESQ_DEPTH = 2;
  localparam int RESQ_AW = $clog2(RESQ_DEPTH);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_QUERY,
    CMD_RANGE_ERR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic [POS_W-1:0] pos_left;
    logic [COL_W-1:0] color;
    logic [POS_W-1:0] right;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] distinct_count;
    logic range_error;
  } res_t;

  typedef struct packed {
    logic clearing;
    logic [POS_W-1:0] window_left;
    logic [POS_W-1:0] window_right;
  } exec_status_t;

  typedef enum logic [2:0] {
    EX_CLEAR,
    EX_IDLE,
    EX_DECIDE,
    EX_READ_FREQ,
    EX_WRITE_FREQ,
    EX_REPLY
  } ex_state_t;

endpackage

// ----- src/rdc_front.sv -----
// ----------------------------------------------------------------------------
// rdc_front
// Accepts requests, checks ranges and turns them into commands for the back end.
// ----------------------------------------------------------------------------
module rdc_front (
  input  logic                       push,
  output logic                       full,
  input  logic                       op,
  input  logic [rdc_pkg::POS_W-1:0]  position,
  input  logic [rdc_pkg::COL_W-1:0]  color,
  input  logic [rdc_pkg::POS_W-1:0]  range_left,
  input  logic [rdc_pkg::POS_W-1:0]  range_right,
  input  logic                       q_full,
  input  logic                       clearing,
  output logic                       cmd_push,
  output rdc_pkg::cmd_t              cmd
);

  logic accept;
  logic pos_ok;
  logic col_ok;
  logic range_bad;

  assign full   = q_full || clearing;
  assign accept = push && !full;

  assign pos_ok = (position != '0) &&
                  (position <= rdc_pkg::POS_W'(rdc_pkg::MAX_ELEMENTS));
  assign col_ok = (32'(color) < rdc_pkg::VALUE_LEVELS);
  assign range_bad = (range_left == '0) ||
                     (range_right > rdc_pkg::POS_W'(rdc_pkg::MAX_ELEMENTS)) ||
                     (range_left > range_right);

  always_comb begin
    cmd.color = color;
    cmd.right = range_right;
    if (op == rdc_pkg::OP_LOAD) begin
      // loads outside the array or value range are dropped here
      cmd_push     = accept && pos_ok && col_ok;
      cmd.kind     = rdc_pkg::CMD_LOAD;
      cmd.pos_left = position;
    end else begin
      cmd_push     = accept;
      cmd.kind     = range_bad ? rdc_pkg::CMD_RANGE_ERR : rdc_pkg::CMD_QUERY;
      cmd.pos_left = range_left;
    end
  end

endmodule

// ----- src/rdc_cmdq.sv -----
// ----------------------------------------------------------------------------
// rdc_cmdq
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rdc_cmdq (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  rdc_pkg::cmd_t  wr_data,
  output logic           q_full,
  input  logic           rd_en,
  output logic           q_empty,
  output rdc_pkg::cmd_t  rd_data
);

  rdc_pkg::cmd_t entries [rdc_pkg::CMDQ_DEPTH];
  logic [rdc_pkg::CMDQ_AW-1:0] wr_ptr;
  logic [rdc_pkg::CMDQ_AW-1:0] rd_ptr;
  logic [rdc_pkg::CMDQ_AW:0]   count;
  logic do_wr;
  logic do_rd;

  assign q_full  = (count == (rdc_pkg::CMDQ_AW + 1)'(rdc_pkg::CMDQ_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/rdc_exec.sv -----
// ----------------------------------------------------------------------------
// rdc_exec
// Back end: element store, frequency table and the window walk sequencer.
// ----------------------------------------------------------------------------
module rdc_exec (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_empty,
  input  rdc_pkg::cmd_t         cmd_head,
  output logic                  cmd_pop,
  input  logic                  res_full,
  output logic                  res_push,
  output rdc_pkg::res_t         res_data,
  output rdc_pkg::exec_status_t status
);

  localparam int POS_W  = rdc_pkg::POS_W;
  localparam int ADDR_W = rdc_pkg::ADDR_W;
  localparam int VAL_AW = rdc_pkg::VAL_AW;
  localparam int FREQ_W = rdc_pkg::FREQ_W;
  localparam int CNT_W  = rdc_pkg::CNT_W;

  rdc_pkg::ex_state_t state;
  rdc_pkg::ex_state_t state_next;

  logic [rdc_pkg::COL_W-1:0] elem_mem [rdc_pkg::MAX_ELEMENTS];
  logic [FREQ_W-1:0]         freq_mem [rdc_pkg::VALUE_LEVELS];

  rdc_pkg::cmd_t     cur;
  logic [VAL_AW-1:0] clr_addr;
  logic [POS_W-1:0]  wl;
  logic [POS_W-1:0]  wr;
  logic [CNT_W-1:0]  distinct;
  logic [CNT_W-1:0]  distinct_next;
  logic              step_add;
  logic              load_mode;
  logic              load_new;
  logic [VAL_AW-1:0] val;
  logic [rdc_pkg::COL_W-1:0] elem_q;
  logic [FREQ_W-1:0] freq_q;

  // memory port controls
  logic                      elem_we;
  logic [ADDR_W-1:0]         elem_waddr;
  logic [rdc_pkg::COL_W-1:0] elem_wdata;
  logic [ADDR_W-1:0]         elem_raddr;
  logic                      freq_we;
  logic [VAL_AW-1:0]         freq_waddr;
  logic [FREQ_W-1:0]         freq_wdata;
  logic [VAL_AW-1:0]         freq_raddr;

  // walk decision
  logic             walk_done;
  logic             walk_add;
  logic [POS_W-1:0] walk_pos;
  logic [POS_W-1:0] walk_wl;
  logic [POS_W-1:0] walk_wr;
  logic             head_in_win;

  assign head_in_win = (cmd_head.pos_left >= wl) && (cmd_head.pos_left <= wr);

  // extend left, extend right, shrink left, shrink right
  always_comb begin
    walk_done = 1'b0;
    walk_add  = 1'b0;
    walk_pos  = wl;
    walk_wl   = wl;
    walk_wr   = wr;
    if (wl > cur.pos_left) begin
      walk_add = 1'b1;
      walk_pos = wl - 1'b1;
      walk_wl  = wl - 1'b1;
    end else if (wr < cur.right) begin
      walk_add = 1'b1;
      walk_pos = wr + 1'b1;
      walk_wr  = wr + 1'b1;
    end else if (wl < cur.pos_left) begin
      walk_pos = wl;
      walk_wl  = wl + 1'b1;
    end else if (wr > cur.right) begin
      walk_pos = wr;
      walk_wr  = wr - 1'b1;
    end else begin
      walk_done = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rdc_pkg::EX_CLEAR: begin
        if (clr_addr == VAL_AW'(rdc_pkg::VALUE_LEVELS - 1)) begin
          state_next = rdc_pkg::EX_IDLE;
        end
      end
      rdc_pkg::EX_IDLE: begin
        if (!cmd_empty) begin
          case (cmd_head.kind)
            rdc_pkg::CMD_LOAD: begin
              if (head_in_win) begin
                state_next = rdc_pkg::EX_READ_FREQ;
              end
            end
            rdc_pkg::CMD_QUERY: state_next = rdc_pkg::EX_DECIDE;
            default: state_next = rdc_pkg::EX_REPLY;
          endcase
        end
      end
      rdc_pkg::EX_DECIDE: begin
        state_next = walk_done ? rdc_pkg::EX_REPLY : rdc_pkg::EX_READ_FREQ;
      end
      rdc_pkg::EX_READ_FREQ: state_next = rdc_pkg::EX_WRITE_FREQ;
      rdc_pkg::EX_WRITE_FREQ: begin
        if (load_mode && !load_new) begin
          state_next = rdc_pkg::EX_READ_FREQ;
        end else if (load_mode) begin
          state_next = rdc_pkg::EX_IDLE;
        end else begin
          state_next = rdc_pkg::EX_DECIDE;
        end
      end
      rdc_pkg::EX_REPLY: begin
        if (!res_full) begin
          state_next = rdc_pkg::EX_IDLE;
        end
      end
      default: state_next = rdc_pkg::EX_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop       = 1'b0;
    res_push      = 1'b0;
    res_data      = '0;
    elem_we       = 1'b0;
    elem_waddr    = ADDR_W'(cur.pos_left - 1'b1);
    elem_wdata    = cur.color;
    elem_raddr    = ADDR_W'(walk_pos - 1'b1);
    freq_we       = 1'b0;
    freq_waddr    = val;
    freq_wdata    = freq_q + 1'b1;
    freq_raddr    = load_new ? VAL_AW'(cur.color) : VAL_AW'(elem_q);
    distinct_next = distinct;
    case (state)
      rdc_pkg::EX_CLEAR: begin
        freq_we    = 1'b1;
        freq_waddr = clr_addr;
        freq_wdata = '0;
      end
      rdc_pkg::EX_IDLE: begin
        cmd_pop    = !cmd_empty;
        elem_raddr = ADDR_W'(cmd_head.pos_left - 1'b1);
        elem_waddr = ADDR_W'(cmd_head.pos_left - 1'b1);
        elem_wdata = cmd_head.color;
        // a load outside the window only touches the element store
        elem_we    = !cmd_empty && (cmd_head.kind == rdc_pkg::CMD_LOAD) && !head_in_win;
      end
      rdc_pkg::EX_WRITE_FREQ: begin
        if (step_add) begin
          freq_we = 1'b1;
          if (freq_q == '0) begin
            distinct_next = distinct + 1'b1;
          end
        end else begin
          freq_we    = (freq_q != '0);
          freq_wdata = freq_q - 1'b1;
          if (freq_q == FREQ_W'(1)) begin
            distinct_next = distinct - 1'b1;
          end
        end
        // old value is out, now store the new one
        elem_we = load_mode && !load_new;
      end
      rdc_pkg::EX_REPLY: begin
        res_push = !res_full;
        if (cur.kind == rdc_pkg::CMD_RANGE_ERR) begin
          res_data.distinct_count = '0;
          res_data.range_error    = 1'b1;
        end else begin
          res_data.distinct_count = distinct;
          res_data.range_error    = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (elem_we) begin
      elem_mem[elem_waddr] <= elem_wdata;
    end
    elem_q <= elem_mem[elem_raddr];
  end

  always_ff @(posedge clk) begin
    if (freq_we) begin
      freq_mem[freq_waddr] <= freq_wdata;
    end
    freq_q <= freq_mem[freq_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == rdc_pkg::EX_IDLE && !cmd_empty) begin
      cur <= cmd_head;
    end
    if (state == rdc_pkg::EX_READ_FREQ) begin
      val <= freq_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rdc_pkg::EX_CLEAR;
      clr_addr  <= '0;
      wl        <= POS_W'(1);
      wr        <= '0;
      distinct  <= '0;
      step_add  <= 1'b0;
      load_mode <= 1'b0;
      load_new  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        rdc_pkg::EX_CLEAR: clr_addr <= clr_addr + 1'b1;
        rdc_pkg::EX_IDLE: begin
          if (!cmd_empty) begin
            load_mode <= (cmd_head.kind == rdc_pkg::CMD_LOAD);
            load_new  <= 1'b0;
            step_add  <= 1'b0;
          end
        end
        rdc_pkg::EX_DECIDE: begin
          if (!walk_done) begin
            wl       <= walk_wl;
            wr       <= walk_wr;
            step_add <= walk_add;
          end
        end
        rdc_pkg::EX_WRITE_FREQ: begin
          distinct <= distinct_next;
          if (load_mode && !load_new) begin
            load_new <= 1'b1;
            step_add <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign status.clearing     = (state == rdc_pkg::EX_CLEAR);
  assign status.window_left  = wl;
  assign status.window_right = wr;

endmodule

// ----- src/rdc_resq.sv -----
// ----------------------------------------------------------------------------
// rdc_resq
// Two-entry result queue that decouples the back end from the receiver.
// ----------------------------------------------------------------------------
module rdc_resq (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  rdc_pkg::res_t  wr_data,
  output logic           q_full,
  input  logic           rd_en,
  output logic           q_empty,
  output rdc_pkg::res_t  rd_data
);

  rdc_pkg::res_t entries [rdc_pkg::RESQ_DEPTH];
  logic [rdc_pkg::RESQ_AW-1:0] wr_ptr;
  logic [rdc_pkg::RESQ_AW-1:0] rd_ptr;
  logic [rdc_pkg::RESQ_AW:0]   count;
  logic do_wr;
  logic do_rd;

  assign q_full  = (count == (rdc_pkg::RESQ_AW + 1)'(rdc_pkg::RESQ_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/range_distinct_count_window_core.sv -----
// ----------------------------------------------------------------------------
// range_distinct_count_window_core
// Distinct value count over a sliding window of a loadable element array.
// ----------------------------------------------------------------------------
// Requests enter through push/full and are taken when push is high and full
// is low. op selects a load (position, color) or a query (range_left,
// range_right). Loads give no result; every query gives one result, shown on
// distinct_count/range_error while empty is low and taken with pop.
// A four-entry command queue sits between request decode and the back end,
// and a two-entry result queue sits in front of the receiver, so requests
// keep flowing while a result waits.
// Back end work per request: a load outside the window only writes the
// element store; a load inside the window reads the old element, takes its
// count out of the frequency table, then adds the new color; a bad range
// goes straight to the reply; a query walks the window one move at a time
// and then replies. Each window move is one element read, one frequency
// read and one frequency write. After reset the frequency table is cleared
// one entry per cycle, with full held high. The window is then empty
// (left 1, right 0). If pop stays low the result queue fills, the back
// end waits, then the command queue fills and full rises.
// ----------------------------------------------------------------------------
module range_distinct_count_window_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic                       op,
  input  logic [rdc_pkg::POS_W-1:0]  position,
  input  logic [rdc_pkg::COL_W-1:0]  color,
  input  logic [rdc_pkg::POS_W-1:0]  range_left,
  input  logic [rdc_pkg::POS_W-1:0]  range_right,
  output logic                       empty,
  input  logic                       pop,
  output logic [rdc_pkg::CNT_W-1:0]  distinct_count,
  output logic                       range_error
);

  logic                  cmd_push;
  rdc_pkg::cmd_t         cmd_in;
  logic                  cmdq_full;
  logic                  cmdq_empty;
  rdc_pkg::cmd_t         cmd_head;
  logic                  cmd_pop;
  logic                  res_push;
  rdc_pkg::res_t         res_in;
  logic                  resq_full;
  rdc_pkg::res_t         res_head;
  rdc_pkg::exec_status_t status;

  rdc_front u_front (
    .push        (push),
    .full        (full),
    .op          (op),
    .position    (position),
    .color       (color),
    .range_left  (range_left),
    .range_right (range_right),
    .q_full      (cmdq_full),
    .clearing    (status.clearing),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in)
  );

  rdc_cmdq u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .q_full  (cmdq_full),
    .rd_en   (cmd_pop),
    .q_empty (cmdq_empty),
    .rd_data (cmd_head)
  );

  rdc_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmdq_empty),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_full  (resq_full),
    .res_push  (res_push),
    .res_data  (res_in),
    .status    (status)
  );

  rdc_resq u_resq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .q_full  (resq_full),
    .rd_en   (pop),
    .q_empty (empty),
    .rd_data (res_head)
  );

  assign distinct_count = res_head.distinct_count;
  assign range_error    = res_head.range_error;

  // no request reaches the command queue while the table is being cleared
  a_no_cmd_while_clearing: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !status.clearing)
    else $error("command pushed during clearing pass");

  // the back end never pushes into a full result queue
  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !resq_full)
    else $error("result queue overflow");

  // window stays inside the array and never inverts by more than empty
  a_window_bounds: assert property (@(posedge clk) disable iff (rst)
    !status.clearing |-> (status.window_left != '0) &&
      (status.window_right <= rdc_pkg::POS_W'(rdc_pkg::MAX_ELEMENTS)) &&
      ({1'b0, status.window_left} <= {1'b0, status.window_right} + 1'b1))
    else $error("window out of bounds");

  // an error result always carries a zero count
  a_error_zero_count: assert property (@(posedge clk) disable iff (rst)
    (res_push && res_in.range_error) |-> (res_in.distinct_count == '0))
    else $error("error result with nonzero count");

endmodule
